>>> src/lmfc_pkg.sv
// ----------------------------------------------------------------------------
// lmfc_pkg
// Shared types, command codes and glyph table for the LED matrix frame
// controller.
// ----------------------------------------------------------------------------
package lmfc_pkg;

  // Default geometry and fixed sizes
  localparam int FRAME_ROWS_DEF = 5;
  localparam int FRAME_COLS_DEF = 7;
  localparam int SHADOW_DEPTH   = 8;
  localparam int NUM_MAX        = 99;

  // Command codes
  localparam logic [3:0] FN_CLEAR  = 4'd0;
  localparam logic [3:0] FN_LED    = 4'd1;
  localparam logic [3:0] FN_ROW    = 4'd2;
  localparam logic [3:0] FN_COL    = 4'd3;
  localparam logic [3:0] FN_LOAD   = 4'd4;
  localparam logic [3:0] FN_REDRAW = 4'd5;
  localparam logic [3:0] FN_LEFT   = 4'd6;
  localparam logic [3:0] FN_RIGHT  = 4'd7;
  localparam logic [3:0] FN_UP     = 4'd8;
  localparam logic [3:0] FN_DOWN   = 4'd9;
  localparam logic [3:0] FN_NUMBER = 4'd10;
  localparam logic [3:0] FN_RAWCOL = 4'd11;

  // Controller to datapath command bundle
  typedef struct packed {
    logic       load;   // capture input word payload
    logic       prep;   // apply frame update for the current command
    logic       step;   // produce one register write
    logic [3:0] op;     // current command code
    logic [2:0] row;    // frame row under work
    logic [2:0] col;    // column under work
    logic       last;   // this write ends the command
  } dp_cmd_t;

  // 3x5 digit glyphs, one row of all ten digits per table
  localparam logic [2:0] GLYPH_R0 [10] = '{3'd7, 3'd1, 3'd7, 3'd7, 3'd1,
                                           3'd7, 3'd7, 3'd1, 3'd7, 3'd7};
  localparam logic [2:0] GLYPH_R1 [10] = '{3'd5, 3'd1, 3'd4, 3'd1, 3'd1,
                                           3'd1, 3'd5, 3'd1, 3'd5, 3'd1};
  localparam logic [2:0] GLYPH_R2 [10] = '{3'd5, 3'd1, 3'd7, 3'd3, 3'd7,
                                           3'd7, 3'd7, 3'd1, 3'd7, 3'd7};
  localparam logic [2:0] GLYPH_R3 [10] = '{3'd5, 3'd1, 3'd1, 3'd1, 3'd5,
                                           3'd4, 3'd4, 3'd1, 3'd5, 3'd5};
  localparam logic [2:0] GLYPH_R4 [10] = '{3'd7, 3'd3, 3'd7, 3'd7, 3'd5,
                                           3'd7, 3'd7, 3'd7, 3'd7, 3'd7};

  // Glyph bits for one digit; rows below the glyph are blank
  function automatic logic [2:0] glyph_bits(input logic [2:0] gr, input logic [3:0] d);
    logic [2:0] g;
    case (gr)
      3'd0:    g = GLYPH_R0[d];
      3'd1:    g = GLYPH_R1[d];
      3'd2:    g = GLYPH_R2[d];
      3'd3:    g = GLYPH_R3[d];
      3'd4:    g = GLYPH_R4[d];
      default: g = 3'd0;
    endcase
    return g;
  endfunction

endpackage

>>> src/led_matrix_frame_controller_unit.sv
// ----------------------------------------------------------------------------
// led_matrix_frame_controller_unit
// Command engine for a 5x7 LED matrix behind an 8-digit display driver.
//
//   channel  direction  handshake             words
//   in_      input      in_valid / in_ready   func, row, col, led_on, pattern,
//                                             shown_number
//   out_     output     out_valid / out_ready reg_opcode, reg_data, last_write
//
// A command is accepted, passes the frame update state, then issues one
// register write per step: N writes, N from 1 up to FRAME_ROWS*FRAME_COLS
// (35), set by the row/column walk of the sequencer. Commands that write
// nothing stay idle after the accept. Reset clears frame and shadow at once.
// A stalled output holds the walk; a new command is taken once the last
// write of the previous one sits in the output register.
// ----------------------------------------------------------------------------
module led_matrix_frame_controller_unit
  import lmfc_pkg::*;
#(
  parameter int FRAME_ROWS = FRAME_ROWS_DEF,
  parameter int FRAME_COLS = FRAME_COLS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_func,
  input  logic [2:0] in_row_index,
  input  logic [2:0] in_col_index,
  input  logic       in_led_on,
  input  logic [7:0] in_pattern,
  input  logic [6:0] in_shown_number,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_reg_opcode,
  output logic [7:0] out_reg_data,
  output logic       out_last_write
);

  dp_cmd_t cmd;

  lmfc_ctrl #(
    .FRAME_ROWS(FRAME_ROWS),
    .FRAME_COLS(FRAME_COLS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_row_index(in_row_index),
    .in_col_index(in_col_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd)
  );

  lmfc_dpath #(
    .FRAME_ROWS(FRAME_ROWS),
    .FRAME_COLS(FRAME_COLS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_led_on      (in_led_on),
    .in_pattern     (in_pattern),
    .in_shown_number(in_shown_number),
    .out_reg_opcode (out_reg_opcode),
    .out_reg_data   (out_reg_data),
    .out_last_write (out_last_write)
  );

  // The final write step hands the sequencer back to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && cmd.last) |=> in_ready)
    else $error("input still closed after the final write");

  // A write step never overwrites an unconsumed output word
  a_step_space: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (!out_valid || out_ready))
    else $error("write step over a pending output word");

  // The frame update cycle is followed by the write walk
  a_prep_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.prep |=> !in_ready)
    else $error("idle right after frame update");

  // Each step produces a valid output word
  a_step_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> out_valid)
    else $error("write step without output word");

endmodule

>>> src/lmfc_ctrl.sv
// ----------------------------------------------------------------------------
// lmfc_ctrl
// Command sequencer: decodes a command word, runs the frame update cycle and
// walks rows and columns, issuing one register write per step.
// ----------------------------------------------------------------------------
module lmfc_ctrl
  import lmfc_pkg::*;
#(
  parameter int FRAME_ROWS = FRAME_ROWS_DEF,
  parameter int FRAME_COLS = FRAME_COLS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_func,
  input  logic [2:0] in_row_index,
  input  logic [2:0] in_col_index,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam logic [2:0] ROW_MAX = 3'(FRAME_ROWS - 1);
  localparam logic [2:0] COL_MAX = 3'(FRAME_COLS - 1);
  localparam logic [2:0] SHD_MAX = 3'(SHADOW_DEPTH - 1);

  logic [1:0] state_r, state_nxt;
  logic [3:0] op_r, op_nxt;
  logic [2:0] row_r, row_nxt;
  logic [2:0] col_r, col_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic accept, row_ok, col_ok, has_work, frame_all, single_col;
  logic space, col_end, last;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign space    = !out_valid_r || out_ready;

  // Decode of the incoming word
  always_comb begin
    row_ok     = in_row_index < 3'(FRAME_ROWS);
    col_ok     = {1'b0, in_col_index} < 4'(FRAME_COLS);
    frame_all  = in_func inside {FN_REDRAW, FN_LEFT, FN_RIGHT, FN_UP, FN_DOWN, FN_NUMBER};
    single_col = in_func inside {FN_LED, FN_COL, FN_RAWCOL};
    case (in_func)
      FN_LED:                           has_work = row_ok && col_ok;
      FN_ROW, FN_LOAD:                  has_work = row_ok;
      FN_CLEAR, FN_COL, FN_RAWCOL:      has_work = 1'b1;
      FN_REDRAW, FN_LEFT, FN_RIGHT,
      FN_UP, FN_DOWN, FN_NUMBER:        has_work = 1'b1;
      default:                          has_work = 1'b0;
    endcase
  end

  // End of a column sweep and end of the command
  always_comb begin
    col_end = (op_r == FN_CLEAR) ? (col_r == SHD_MAX) : (col_r == COL_MAX);
    case (op_r)
      FN_CLEAR:                   last = (col_r == SHD_MAX);
      FN_LED, FN_COL, FN_RAWCOL:  last = 1'b1;
      FN_ROW, FN_LOAD:            last = (col_r == COL_MAX);
      default:                    last = (col_r == COL_MAX) && (row_r == ROW_MAX);
    endcase
  end

  // Next state
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = in_func;
          row_nxt = frame_all ? 3'd0 : in_row_index;
          col_nxt = single_col ? in_col_index : 3'd0;
          if (has_work) state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (space) begin
          out_valid_nxt = 1'b1;
          if (last) begin
            state_nxt = S_IDLE;
          end else if (col_end) begin
            col_nxt = 3'd0;
            row_nxt = row_r + 3'd1;
          end else begin
            col_nxt = col_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= FN_CLEAR;
      row_r       <= 3'd0;
      col_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath commands
  always_comb begin
    cmd.load = accept;
    cmd.prep = (state_r == S_PREP);
    cmd.step = (state_r == S_EMIT) && space;
    cmd.op   = op_r;
    cmd.row  = row_r;
    cmd.col  = col_r;
    cmd.last = last;
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/lmfc_dpath.sv
// ----------------------------------------------------------------------------
// lmfc_dpath
// Pattern frame, column shadow and output write register. Applies frame
// updates and forms one register write per step command.
// ----------------------------------------------------------------------------
module lmfc_dpath
  import lmfc_pkg::*;
#(
  parameter int FRAME_ROWS = FRAME_ROWS_DEF,
  parameter int FRAME_COLS = FRAME_COLS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  input  logic       in_led_on,
  input  logic [7:0] in_pattern,
  input  logic [6:0] in_shown_number,
  output logic [3:0] out_reg_opcode,
  output logic [7:0] out_reg_data,
  output logic       out_last_write
);

  localparam int FRW = (FRAME_ROWS > 1) ? $clog2(FRAME_ROWS) : 1;
  localparam int ROT = FRAME_COLS - 1;
  localparam logic [2:0] BIT_TOP = 3'(FRAME_COLS - 1);
  localparam logic [2:0] ROW_TOP = 3'd6;

  typedef logic [FRAME_COLS-1:0] fword_t;

  fword_t     frame_r  [FRAME_ROWS];
  fword_t     frame_nxt[FRAME_ROWS];
  logic [7:0] shadow_r [SHADOW_DEPTH];

  logic       on_r;
  logic [7:0] pat_r;
  logic [3:0] tens_r, units_r;
  logic [3:0] opcode_r;
  logic [7:0] data_r;
  logic       last_r;

  logic [6:0]  num_sat;
  logic [14:0] num_prod;
  logic [3:0]  tens_c;
  logic [6:0]  units_w;

  fword_t     word_f;
  logic [7:0] word8;
  logic       bit_on;
  logic [7:0] sh_cur, led_byte, wr_data;
  logic       wr_en;
  logic [2:0] fcol;
  logic [FRW-1:0] ridx;

  // Split the number into digits: tens by reciprocal of ten
  always_comb begin
    num_sat  = (in_shown_number > 7'(NUM_MAX)) ? 7'(NUM_MAX) : in_shown_number;
    num_prod = 15'(num_sat) * 15'd205;
    tens_c   = num_prod[14:11];
    units_w  = num_sat - {tens_c, 3'b000} - {2'b00, tens_c, 1'b0};
  end

  // Payload capture on command accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      on_r    <= in_led_on;
      pat_r   <= in_pattern;
      tens_r  <= tens_c;
      units_r <= units_w[3:0];
    end
  end

  assign ridx = cmd.row[FRW-1:0];

  // Frame update for load, rotate and number commands
  always_comb begin
    for (int i = 0; i < FRAME_ROWS; i++) frame_nxt[i] = frame_r[i];
    if (cmd.prep) begin
      case (cmd.op)
        FN_LOAD: frame_nxt[ridx] = FRAME_COLS'(pat_r);
        FN_LEFT: begin
          for (int i = 0; i < FRAME_ROWS; i++)
            frame_nxt[i] = (frame_r[i] << 1) | (frame_r[i] >> ROT);
        end
        FN_RIGHT: begin
          for (int i = 0; i < FRAME_ROWS; i++)
            frame_nxt[i] = (frame_r[i] >> 1) | (frame_r[i] << ROT);
        end
        FN_UP: begin
          frame_nxt[0] = frame_r[FRAME_ROWS-1];
          for (int i = 1; i < FRAME_ROWS; i++) frame_nxt[i] = frame_r[i-1];
        end
        FN_DOWN: begin
          frame_nxt[FRAME_ROWS-1] = frame_r[0];
          for (int i = 0; i < FRAME_ROWS - 1; i++) frame_nxt[i] = frame_r[i+1];
        end
        FN_NUMBER: begin
          for (int i = 0; i < FRAME_ROWS; i++)
            frame_nxt[i] = FRAME_COLS'({glyph_bits(3'(i), tens_r), 1'b0,
                                        glyph_bits(3'(i), units_r)});
        end
        default: ;
      endcase
    end
  end

  // One register write: pick the bit into the shadow byte, or clear/column data
  always_comb begin
    word_f   = frame_r[ridx];
    word8    = (cmd.op == FN_ROW) ? pat_r : 8'(word_f);
    fcol     = BIT_TOP - cmd.col;
    bit_on   = (cmd.op == FN_LED) ? on_r : word8[fcol];
    sh_cur   = shadow_r[cmd.col];
    led_byte = sh_cur;
    led_byte[ROW_TOP - cmd.row] = bit_on;
    case (cmd.op)
      FN_CLEAR: begin
        wr_data = 8'd0;
        wr_en   = 1'b1;
      end
      FN_COL: begin
        wr_data = {pat_r[5:0], 2'b00};
        wr_en   = 1'b1;
      end
      FN_RAWCOL: begin
        wr_data = {pat_r[5:0], 2'b00};
        wr_en   = 1'b0;
      end
      default: begin
        wr_data = led_byte;
        wr_en   = 1'b1;
      end
    endcase
  end

  // Frame and shadow storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAME_ROWS; i++) frame_r[i] <= '0;
      for (int k = 0; k < SHADOW_DEPTH; k++) shadow_r[k] <= 8'd0;
    end else begin
      for (int i = 0; i < FRAME_ROWS; i++) frame_r[i] <= frame_nxt[i];
      if (cmd.step && wr_en) shadow_r[cmd.col] <= wr_data;
    end
  end

  // Output write register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      opcode_r <= {1'b0, cmd.col} + 4'd1;
      data_r   <= wr_data;
      last_r   <= cmd.last;
    end
  end

  assign out_reg_opcode = opcode_r;
  assign out_reg_data   = data_r;
  assign out_last_write = last_r;

endmodule
